>>> rtl/epoch_seconds_to_calendar_assert.svh
// Assertion macros used by the port checker of the epoch seconds to calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/esc_pkg.sv
// Package with widths, constants and word types of the epoch seconds to calendar converter.
`default_nettype none

package esc_pkg;

    localparam int SECS_W   = 64;
    localparam int T_W      = 38;
    localparam int DAYS_W   = 22;
    localparam int SOD_W    = 17;
    localparam int ERA_W    = 5;
    localparam int DOE_W    = 18;
    localparam int YOE_W    = 9;
    localparam int DOY_W    = 9;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MINS_W   = 11;

    localparam int EPOCH_YEAR    = 1970;
    localparam int EPOCH_LEAPS   = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                                   + (EPOCH_YEAR - 1) / 400;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int YEARS_PER_ERA = 400;
    localparam int DAYS_PER_YEAR = 365;
    localparam int EPOCH_SHIFT   = 719468;
    localparam int LAST_DOE      = DAYS_PER_ERA - 1;

    // 86400 is 675 shifted left by seven.
    localparam int DAY_LOW_W = 7;
    localparam int DAY_ODD   = SECS_PER_DAY >> DAY_LOW_W;
    localparam int DAY_X_W   = T_W - DAY_LOW_W;
    localparam int DAY_ODD_W = 10;

    // Reciprocals for exact division of bounded values by constants.
    localparam int DAY_SH = 41;
    localparam logic [31:0] RCP_DAY = 32'(((64'd1 << DAY_SH) / 64'(DAY_ODD)) + 64'd1);
    localparam int MIN_SH = 19;
    localparam logic [15:0] RCP_MIN = 16'(((64'd1 << MIN_SH) / 64'd15) + 64'd1);
    localparam int HR_SH = 13;
    localparam logic [9:0] RCP_HR = 10'(((64'd1 << HR_SH) / 64'd15) + 64'd1);
    localparam int ERA_SH = 40;
    localparam logic [22:0] RCP_ERA = 23'(((64'd1 << ERA_SH) / 64'(DAYS_PER_ERA)) + 64'd1);
    localparam int D4Y_SH = 29;
    localparam logic [18:0] RCP_D4Y = 19'(((64'd1 << D4Y_SH) / 64'd1460) + 64'd1);
    localparam int D100Y_SH = 34;
    localparam logic [18:0] RCP_D100Y = 19'(((64'd1 << D100Y_SH) / 64'd36524) + 64'd1);
    localparam int Y365_SH = 27;
    localparam logic [18:0] RCP_Y365 = 19'(((64'd1 << Y365_SH) / 64'd365) + 64'd1);
    localparam int C100_SH = 16;
    localparam logic [9:0] RCP_C100 = 10'(((64'd1 << C100_SH) / 64'd100) + 64'd1);
    localparam int M153_SH = 19;
    localparam logic [11:0] RCP_M153 = 12'(((64'd1 << M153_SH) / 64'd153) + 64'd1);
    localparam int F5_SH = 14;
    localparam logic [11:0] RCP_F5 = 12'(((64'd1 << F5_SH) / 64'd5) + 64'd1);

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
        logic              flag;
    } esc_day_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic                flag;
    } esc_hms_t;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        esc_hms_t          hms;
    } esc_tod_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        esc_hms_t           hms;
    } esc_cal_t;

endpackage

`default_nettype wire

>>> rtl/esc_ctl.sv
// Valid and stage enable control of one pipeline segment with per-stage backpressure.
`default_nettype none

module esc_ctl #(
    parameter int STAGES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAGES-1:0] en
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    assign en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;

    for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/esc_split.sv
// Input clamp and split of the second count into whole days and second of day.
`default_nettype none

module esc_split #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [esc_pkg::SECS_W-1:0]     in_secs,
    output logic                           out_valid,
    input  logic                           out_ready,
    output esc_pkg::esc_day_t              out_day
);

    localparam int STAGES    = 3;
    localparam int LEAPS_END = MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
    localparam int DAYS_END  = 365 * (MAX_YEAR + 1 - esc_pkg::EPOCH_YEAR) + LEAPS_END
                               - esc_pkg::EPOCH_LEAPS;
    localparam logic [esc_pkg::SECS_W-1:0] LAST =
        64'(DAYS_END) * 64'(esc_pkg::SECS_PER_DAY) - 64'd1;
    localparam int PROD_W = esc_pkg::DAY_X_W + 32;

    logic [STAGES-1:0] en;

    logic [esc_pkg::T_W-1:0]           t_reg;
    logic [esc_pkg::T_W-1:0]           t_next;
    logic                              flag0_reg;
    logic                              flag0_next;
    logic [PROD_W-1:0]                 prod_reg;
    logic [esc_pkg::DAY_X_W-1:0]       x_reg;
    logic [esc_pkg::DAY_LOW_W-1:0]     lo_reg;
    logic                              flag1_reg;
    esc_pkg::esc_day_t                 day_reg;
    esc_pkg::esc_day_t                 day_next;
    logic [esc_pkg::DAYS_W-1:0]        days_q;
    logic [esc_pkg::DAY_X_W-1:0]       rem_wide;

    esc_ctl #(
        .STAGES(STAGES)
    ) u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .en       (en)
    );

    always_comb
    begin
        priority if (in_secs[esc_pkg::SECS_W-1] || in_secs == '0)
        begin
            t_next     = '0;
            flag0_next = 1'b0;
        end
        else if (in_secs > LAST)
        begin
            t_next     = LAST[esc_pkg::T_W-1:0];
            flag0_next = 1'b1;
        end
        else
        begin
            t_next     = in_secs[esc_pkg::T_W-1:0];
            flag0_next = 1'b0;
        end
    end

    always_comb
    begin
        days_q        = prod_reg[PROD_W-1:esc_pkg::DAY_SH];
        rem_wide      = x_reg - esc_pkg::DAY_X_W'(days_q) * esc_pkg::DAY_X_W'(esc_pkg::DAY_ODD);
        day_next.days = days_q;
        day_next.sod  = {rem_wide[esc_pkg::DAY_ODD_W-1:0], lo_reg};
        day_next.flag = flag1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_reg     <= t_next;
            flag0_reg <= flag0_next;
        end
        if (en[1])
        begin
            prod_reg  <= PROD_W'(t_reg[esc_pkg::T_W-1:esc_pkg::DAY_LOW_W])
                         * PROD_W'(esc_pkg::RCP_DAY);
            x_reg     <= t_reg[esc_pkg::T_W-1:esc_pkg::DAY_LOW_W];
            lo_reg    <= t_reg[esc_pkg::DAY_LOW_W-1:0];
            flag1_reg <= flag0_reg;
        end
        if (en[2])
        begin
            day_reg <= day_next;
        end
    end

    assign out_day = day_reg;

endmodule

`default_nettype wire

>>> rtl/esc_clock.sv
// Split of the second of day into hour, minute and second.
`default_nettype none

module esc_clock (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  esc_pkg::esc_day_t in_day,
    output logic              out_valid,
    input  logic              out_ready,
    output esc_pkg::esc_tod_t out_tod
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] en;

    logic [30:0]                     pm_reg;
    esc_pkg::esc_day_t               d0_reg;
    logic [esc_pkg::MINS_W-1:0]      mins1_reg;
    logic [esc_pkg::SECOND_W-1:0]    sec1_reg;
    logic [esc_pkg::DAYS_W-1:0]      days1_reg;
    logic                            flag1_reg;
    logic [18:0]                     ph_reg;
    logic [esc_pkg::MINS_W-1:0]      mins2_reg;
    logic [esc_pkg::SECOND_W-1:0]    sec2_reg;
    logic [esc_pkg::DAYS_W-1:0]      days2_reg;
    logic                            flag2_reg;
    esc_pkg::esc_tod_t               tod_reg;
    esc_pkg::esc_tod_t               tod_next;
    logic [esc_pkg::MINS_W-1:0]      mins_q;
    logic [esc_pkg::SOD_W-1:0]       sec_wide;
    logic [esc_pkg::MINS_W-1:0]      min_wide;

    esc_ctl #(
        .STAGES(STAGES)
    ) u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .en       (en)
    );

    always_comb
    begin
        mins_q   = pm_reg[esc_pkg::MIN_SH+esc_pkg::MINS_W-1:esc_pkg::MIN_SH];
        sec_wide = d0_reg.sod - esc_pkg::SOD_W'(mins_q) * esc_pkg::SOD_W'(esc_pkg::SECS_PER_MIN);
    end

    always_comb
    begin
        tod_next.days       = days2_reg;
        tod_next.hms.hour   = ph_reg[esc_pkg::HR_SH+esc_pkg::HOUR_W-1:esc_pkg::HR_SH];
        min_wide            = mins2_reg - esc_pkg::MINS_W'(tod_next.hms.hour)
                              * esc_pkg::MINS_W'(esc_pkg::MINS_PER_HOUR);
        tod_next.hms.minute = min_wide[esc_pkg::MINUTE_W-1:0];
        tod_next.hms.second = sec2_reg;
        tod_next.hms.flag   = flag2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pm_reg <= 31'(in_day.sod[esc_pkg::SOD_W-1:2]) * 31'(esc_pkg::RCP_MIN);
            d0_reg <= in_day;
        end
        if (en[1])
        begin
            mins1_reg <= mins_q;
            sec1_reg  <= sec_wide[esc_pkg::SECOND_W-1:0];
            days1_reg <= d0_reg.days;
            flag1_reg <= d0_reg.flag;
        end
        if (en[2])
        begin
            ph_reg    <= 19'(mins1_reg[esc_pkg::MINS_W-1:2]) * 19'(esc_pkg::RCP_HR);
            mins2_reg <= mins1_reg;
            sec2_reg  <= sec1_reg;
            days2_reg <= days1_reg;
            flag2_reg <= flag1_reg;
        end
        if (en[3])
        begin
            tod_reg <= tod_next;
        end
    end

    assign out_tod = tod_reg;

endmodule

`default_nettype wire

>>> rtl/esc_civil.sv
// Conversion of a day count since the epoch into Gregorian year, month and day.
`default_nettype none

module esc_civil (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  esc_pkg::esc_tod_t in_tod,
    output logic              out_valid,
    input  logic              out_ready,
    output esc_pkg::esc_cal_t out_cal
);

    localparam int STAGES = 11;

    logic [STAGES-1:0] en;

    esc_pkg::esc_hms_t              hms_reg [STAGES-1];
    logic [esc_pkg::DAYS_W-1:0]     z0_next;
    logic [44:0]                    pe0_reg;
    logic [esc_pkg::DAYS_W-1:0]     z0_reg;
    logic [esc_pkg::ERA_W-1:0]      era1_reg;
    logic [esc_pkg::DOE_W-1:0]      doe1_reg;
    logic [esc_pkg::ERA_W-1:0]      era_q;
    logic [esc_pkg::DAYS_W-1:0]     doe_wide;
    logic [36:0]                    pa2_reg;
    logic [36:0]                    pb2_reg;
    logic                           c2_reg;
    logic [esc_pkg::DOE_W-1:0]      doe2_reg;
    logic [esc_pkg::ERA_W-1:0]      era2_reg;
    logic [esc_pkg::DOE_W-1:0]      x3_reg;
    logic [esc_pkg::DOE_W-1:0]      doe3_reg;
    logic [esc_pkg::ERA_W-1:0]      era3_reg;
    logic [36:0]                    py4_reg;
    logic [esc_pkg::DOE_W-1:0]      doe4_reg;
    logic [esc_pkg::ERA_W-1:0]      era4_reg;
    logic [esc_pkg::YOE_W-1:0]      yoe_q;
    logic [esc_pkg::YOE_W-1:0]      yoe5_reg;
    logic [18:0]                    p100_5_reg;
    logic [esc_pkg::YEAR_W-1:0]     ybase5_reg;
    logic [esc_pkg::DOE_W-1:0]      doe5_reg;
    logic [esc_pkg::DOE_W-1:0]      ystart;
    logic [esc_pkg::DOE_W-1:0]      doy_wide;
    logic [esc_pkg::DOY_W-1:0]      doy6_reg;
    logic [esc_pkg::YEAR_W-1:0]     ybase6_reg;
    logic [22:0]                    pm7_reg;
    logic [esc_pkg::DOY_W-1:0]      doy7_reg;
    logic [esc_pkg::YEAR_W-1:0]     ybase7_reg;
    logic [esc_pkg::MONTH_W-1:0]    mp8_reg;
    logic [10:0]                    q8_reg;
    logic [esc_pkg::DOY_W-1:0]      doy8_reg;
    logic [esc_pkg::YEAR_W-1:0]     ybase8_reg;
    logic [22:0]                    p5_9_reg;
    logic [esc_pkg::MONTH_W-1:0]    mp9_reg;
    logic [esc_pkg::DOY_W-1:0]      doy9_reg;
    logic [esc_pkg::YEAR_W-1:0]     ybase9_reg;
    logic [esc_pkg::DOY_W-1:0]      day_wide;
    esc_pkg::esc_cal_t              cal_reg;
    esc_pkg::esc_cal_t              cal_next;

    esc_ctl #(
        .STAGES(STAGES)
    ) u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .en       (en)
    );

    always_comb
    begin
        z0_next  = in_tod.days + esc_pkg::DAYS_W'(esc_pkg::EPOCH_SHIFT);
        era_q    = pe0_reg[esc_pkg::ERA_SH+esc_pkg::ERA_W-1:esc_pkg::ERA_SH];
        doe_wide = z0_reg - esc_pkg::DAYS_W'(era_q) * esc_pkg::DAYS_W'(esc_pkg::DAYS_PER_ERA);
        yoe_q    = py4_reg[esc_pkg::Y365_SH+esc_pkg::YOE_W-1:esc_pkg::Y365_SH];
        ystart   = esc_pkg::DOE_W'(yoe5_reg) * esc_pkg::DOE_W'(esc_pkg::DAYS_PER_YEAR)
                   + esc_pkg::DOE_W'(yoe5_reg >> 2)
                   - esc_pkg::DOE_W'(p100_5_reg[18:esc_pkg::C100_SH]);
        doy_wide = doe5_reg - ystart;
    end

    always_comb
    begin
        day_wide = doy9_reg - p5_9_reg[22:esc_pkg::F5_SH] + esc_pkg::DOY_W'(1);
        cal_next.day = day_wide[esc_pkg::DAY_W-1:0];
        if (mp9_reg < esc_pkg::MONTH_W'(10))
        begin
            cal_next.month = mp9_reg + esc_pkg::MONTH_W'(3);
        end
        else
        begin
            cal_next.month = mp9_reg - esc_pkg::MONTH_W'(9);
        end
        cal_next.year = ybase9_reg + esc_pkg::YEAR_W'(cal_next.month <= esc_pkg::MONTH_W'(2));
        cal_next.hms  = hms_reg[STAGES-2];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hms_reg[0] <= in_tod.hms;
            pe0_reg    <= 45'(z0_next) * 45'(esc_pkg::RCP_ERA);
            z0_reg     <= z0_next;
        end
        for (int k = 1; k < STAGES - 1; k++)
        begin
            if (en[k])
            begin
                hms_reg[k] <= hms_reg[k-1];
            end
        end
        if (en[1])
        begin
            era1_reg <= era_q;
            doe1_reg <= doe_wide[esc_pkg::DOE_W-1:0];
        end
        if (en[2])
        begin
            pa2_reg  <= 37'(doe1_reg) * 37'(esc_pkg::RCP_D4Y);
            pb2_reg  <= 37'(doe1_reg) * 37'(esc_pkg::RCP_D100Y);
            c2_reg   <= doe1_reg == esc_pkg::DOE_W'(esc_pkg::LAST_DOE);
            doe2_reg <= doe1_reg;
            era2_reg <= era1_reg;
        end
        if (en[3])
        begin
            x3_reg   <= doe2_reg + esc_pkg::DOE_W'(pb2_reg[36:esc_pkg::D100Y_SH])
                        - esc_pkg::DOE_W'(pa2_reg[36:esc_pkg::D4Y_SH])
                        - esc_pkg::DOE_W'(c2_reg);
            doe3_reg <= doe2_reg;
            era3_reg <= era2_reg;
        end
        if (en[4])
        begin
            py4_reg  <= 37'(x3_reg) * 37'(esc_pkg::RCP_Y365);
            doe4_reg <= doe3_reg;
            era4_reg <= era3_reg;
        end
        if (en[5])
        begin
            yoe5_reg   <= yoe_q;
            p100_5_reg <= 19'(yoe_q) * 19'(esc_pkg::RCP_C100);
            ybase5_reg <= esc_pkg::YEAR_W'(yoe_q) + esc_pkg::YEAR_W'(era4_reg)
                          * esc_pkg::YEAR_W'(esc_pkg::YEARS_PER_ERA);
            doe5_reg   <= doe4_reg;
        end
        if (en[6])
        begin
            doy6_reg   <= doy_wide[esc_pkg::DOY_W-1:0];
            ybase6_reg <= ybase5_reg;
        end
        if (en[7])
        begin
            pm7_reg    <= (23'(doy6_reg) * 23'd5 + 23'd2) * 23'(esc_pkg::RCP_M153);
            doy7_reg   <= doy6_reg;
            ybase7_reg <= ybase6_reg;
        end
        if (en[8])
        begin
            mp8_reg    <= pm7_reg[esc_pkg::M153_SH+esc_pkg::MONTH_W-1:esc_pkg::M153_SH];
            q8_reg     <= 11'(pm7_reg[esc_pkg::M153_SH+esc_pkg::MONTH_W-1:esc_pkg::M153_SH])
                          * 11'd153 + 11'd2;
            doy8_reg   <= doy7_reg;
            ybase8_reg <= ybase7_reg;
        end
        if (en[9])
        begin
            p5_9_reg   <= 23'(q8_reg) * 23'(esc_pkg::RCP_F5);
            mp9_reg    <= mp8_reg;
            doy9_reg   <= doy8_reg;
            ybase9_reg <= ybase8_reg;
        end
        if (en[10])
        begin
            cal_reg <= cal_next;
        end
    end

    assign out_cal = cal_reg;

endmodule

`default_nettype wire

>>> rtl/epoch_seconds_to_calendar.sv
// Top level of the epoch seconds to Gregorian calendar converter.
//
// The input stream carries one signed 64-bit count of seconds since
// 1970-01-01 00:00:00 per word. The output stream gives one word per input
// word, in order, with year, month, day, hour, minute and second in tdata and
// the out-of-range flag in tuser. Zero and negative counts give the epoch
// itself; counts past the last second of year MAX_YEAR give that second with
// the flag set.
// The datapath is an 18-stage pipeline: 3 stages clamp the count and divide it
// into days and second of day, 4 split the second of day, and 11 turn the day
// count into a date. Each stage holds about one constant multiplication.
// One word can be accepted in every cycle unless the pipeline is full and the
// receiver stalls. Every stage has its own valid bit and moves on whenever
// the next one is empty or moving, so empty stages fill up while the receiver
// stalls and the input is held off only when all 18 stages are full.
// A stalled output word holds its value until it is taken.
// Reset empties the pipeline; there is no other state.
`default_nettype none

module epoch_seconds_to_calendar #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // year, month, day, hour, minute, second
    output logic        m_axis_tuser    // out_of_range
);

    logic              day_valid;
    logic              day_ready;
    esc_pkg::esc_day_t day_word;
    logic              tod_valid;
    logic              tod_ready;
    esc_pkg::esc_tod_t tod_word;
    esc_pkg::esc_cal_t cal_word;

    esc_split #(
        .MAX_YEAR(MAX_YEAR)
    ) u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_secs  (s_axis_tdata),
        .out_valid(day_valid),
        .out_ready(day_ready),
        .out_day  (day_word)
    );

    esc_clock u_clock (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (day_valid),
        .in_ready (day_ready),
        .in_day   (day_word),
        .out_valid(tod_valid),
        .out_ready(tod_ready),
        .out_tod  (tod_word)
    );

    esc_civil u_civil (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tod_valid),
        .in_ready (tod_ready),
        .in_tod   (tod_word),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_cal  (cal_word)
    );

    assign m_axis_tdata = {cal_word.hms.second, cal_word.hms.minute, cal_word.hms.hour,
                           cal_word.day, cal_word.month, cal_word.year};
    assign m_axis_tuser = cal_word.hms.flag;

endmodule

`default_nettype wire

>>> rtl/esc_checker.sv
// Port checker of the epoch seconds to calendar converter and its bind.
`default_nettype none

`include "epoch_seconds_to_calendar_assert.svh"

module esc_checker #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tuser
);

    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        fields_ok;
    logic        year_ok;
    logic        last_ok;

    assign year   = m_axis_tdata[13:0];
    assign month  = m_axis_tdata[17:14];
    assign day    = m_axis_tdata[22:18];
    assign hour   = m_axis_tdata[27:23];
    assign minute = m_axis_tdata[33:28];
    assign second = m_axis_tdata[39:34];

    assign fields_ok = month != 4'd0 && month <= 4'd12 && day != 5'd0 && hour < 5'd24
                       && minute < 6'd60 && second < 6'd60;
    assign year_ok   = year >= 14'(esc_pkg::EPOCH_YEAR) && year <= 14'(MAX_YEAR);
    assign last_ok   = year == 14'(MAX_YEAR) && month == 4'd12 && day == 5'd31
                       && hour == 5'd23 && minute == 6'd59 && second == 6'd59;

    `ESC_ASSERT_NXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
    `ESC_ASSERT_IMP(a_fields, clk, rst_n, m_axis_tvalid, fields_ok, "time or date field out of range")
    `ESC_ASSERT_IMP(a_year, clk, rst_n, m_axis_tvalid, year_ok, "year out of range")
    `ESC_ASSERT_IMP(a_saturate, clk, rst_n, m_axis_tvalid && m_axis_tuser, last_ok, "flagged word is not the last second")

endmodule

bind epoch_seconds_to_calendar esc_checker #(
    .MAX_YEAR(MAX_YEAR)
) u_esc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

>>> test/tb_epoch_seconds_to_calendar.sv
// Testbench of the epoch seconds to calendar converter, checking dates against predictions.
module tb_epoch_seconds_to_calendar;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    localparam int MAX_YEAR       = 9999;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AT_DATE   = 100;
    localparam int END_WAIT       = 40;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic                out_of_range;
    } cal_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // epoch_seconds
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // year, month, day, hour, minute, second
    logic        m_axis_tuser;     // out_of_range

    logic [63:0] pending_seconds[$];
    cal_result_t expected_dates[$];

    bit          idle_enable = 1'b1;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned words_sent;
    int unsigned dates_seen;
    int unsigned clamped_count;
    int unsigned saturated_count;
    int unsigned input_stall_cycles;

    function automatic longint unsigned leap_count(longint unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic longint unsigned days_to_year(longint unsigned yy);
        return 365 * (yy - EPOCH_YEAR) + leap_count(yy - 1) - leap_count(EPOCH_YEAR - 1);
    endfunction

    longint unsigned last_second = days_to_year(MAX_YEAR + 1) * SECS_PER_DAY - 1;

    function automatic cal_result_t convert_seconds(logic [63:0] raw);
        longint unsigned t, sod, shifted, era, doe, yoe, yr, doy, mp, dd, mm;
        cal_result_t r;
        r.out_of_range = 1'b0;
        if (raw[63] || raw == 64'd0)
            t = 0;
        else if (raw > last_second)
        begin
            t = last_second;
            r.out_of_range = 1'b1;
        end
        else
            t = raw;
        sod = t % SECS_PER_DAY;
        // Day count shifted to an era that begins on 0000-03-01.
        shifted = t / SECS_PER_DAY + EPOCH_SHIFT;
        era = shifted / DAYS_PER_ERA;
        doe = shifted - era * DAYS_PER_ERA;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / DAYS_PER_YEAR;
        yr = yoe + era * YEARS_PER_ERA;
        doy = doe - (DAYS_PER_YEAR * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        dd = doy - (153 * mp + 2) / 5 + 1;
        mm = (mp < 10) ? mp + 3 : mp - 9;
        if (mm <= 2)
            yr = yr + 1;
        r.year = yr[YEAR_W-1:0];
        r.month = mm[MONTH_W-1:0];
        r.day = dd[DAY_W-1:0];
        r.hour = HOUR_W'(sod / 3600);
        r.minute = MINUTE_W'((sod / 60) % 60);
        r.second = SECOND_W'(sod % 60);
        return r;
    endfunction

    epoch_seconds_to_calendar #(
        .MAX_YEAR(MAX_YEAR)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic offering;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 64'd0;
            send_gap <= 0;
        end
        else
        begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && !s_axis_tready)
                input_stall_cycles++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_dates.push_back(convert_seconds(s_axis_tdata));
                words_sent++;
                if (s_axis_tdata[63] || s_axis_tdata == 64'd0)
                    clamped_count++;
                else if (s_axis_tdata > last_second)
                    saturated_count++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
                else if (idle_enable && $urandom_range(3) == 0)
                    send_gap <= $urandom_range(13, 1) - 1;
                else if (pending_seconds.size() != 0)
                begin
                    s_axis_tdata <= pending_seconds.pop_front();
                    offering = 1'b1;
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        cal_result_t want;
        cal_result_t got;
        logic ready;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                dates_seen++;
                got = {m_axis_tdata[13:0], m_axis_tdata[17:14], m_axis_tdata[22:18],
                       m_axis_tdata[27:23], m_axis_tdata[33:28], m_axis_tdata[39:34],
                       m_axis_tuser};
                if (expected_dates.size() == 0)
                begin
                    $display("%0t ns: unexpected word, expected none, got %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.year !== want.year)
                        $display("%0t ns: year expected %0d, got %0d", $time, want.year, got.year);
                    if (got.month !== want.month)
                        $display("%0t ns: month expected %0d, got %0d", $time, want.month,
                                 got.month);
                    if (got.day !== want.day)
                        $display("%0t ns: day expected %0d, got %0d", $time, want.day, got.day);
                    if (got.hour !== want.hour)
                        $display("%0t ns: hour expected %0d, got %0d", $time, want.hour, got.hour);
                    if (got.minute !== want.minute)
                        $display("%0t ns: minute expected %0d, got %0d", $time, want.minute,
                                 got.minute);
                    if (got.second !== want.second)
                        $display("%0t ns: second expected %0d, got %0d", $time, want.second,
                                 got.second);
                    if (got.out_of_range !== want.out_of_range)
                        $display("%0t ns: out_of_range expected %0d, got %0d", $time,
                                 want.out_of_range, got.out_of_range);
                    if (got !== want)
                        fail_count++;
                end
            end
            if (!hold_done && dates_seen >= HOLD_AT_DATE)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                ready = 1'b0;
            end
            else if (idle_enable && $urandom_range(5) == 0)
            begin
                stall_left = $urandom_range(13, 1) - 1;
                ready = 1'b0;
            end
            else
                ready = 1'b1;
            m_axis_tready <= ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("epoch_seconds_to_calendar test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned kind;
        int unsigned sizes[3];
        longint unsigned yy;
        longint unsigned dd;
        logic [63:0] raw;
        sizes = '{300, 250, 150};
        @(posedge rst_n);
        @(negedge clk);
        pending_seconds.push_back(64'd0);
        pending_seconds.push_back(64'd1);
        pending_seconds.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_seconds.push_back(64'h8000_0000_0000_0000);
        pending_seconds.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        pending_seconds.push_back(last_second);
        pending_seconds.push_back(last_second + 1);
        pending_seconds.push_back(last_second - 1);
        pending_seconds.push_back(last_second - 86399);
        pending_seconds.push_back(64'd59);
        pending_seconds.push_back(64'd60);
        pending_seconds.push_back(64'd3599);
        pending_seconds.push_back(64'd86399);
        pending_seconds.push_back(64'd86400);
        pending_seconds.push_back(64'd68169599);
        pending_seconds.push_back(64'd68169600);
        pending_seconds.push_back(64'd946684799);
        pending_seconds.push_back(64'd951782400);
        pending_seconds.push_back(64'd2147483647);
        pending_seconds.push_back(64'd2147483648);
        pending_seconds.push_back(64'd4107542399);
        pending_seconds.push_back(64'd4107542400);
        pending_seconds.push_back(64'd4294967296);
        for (int phase = 0; phase < 4; phase++)
        begin
            // The sender holds back until every word of the previous phase is out.
            while (pending_seconds.size() != 0 || s_axis_tvalid || expected_dates.size() != 0)
                @(negedge clk);
            if (phase == 3)
                break;
            if (phase == 2)
                idle_enable = 1'b0;
            for (int i = 0; i < sizes[phase]; i++)
            begin
                kind = $urandom_range(99);
                raw = {$urandom, $urandom};
                if (kind < 50)
                    raw = raw % last_second + 1;
                else if (kind < 70)
                begin
                    yy = $urandom_range(MAX_YEAR + 1, EPOCH_YEAR);
                    case ($urandom_range(3))
                        0: dd = days_to_year(yy);
                        1: dd = days_to_year(yy) + 58;
                        2: dd = days_to_year(yy) + 59;
                        default: dd = days_to_year(yy) + 60;
                    endcase
                    raw = dd * SECS_PER_DAY + $urandom_range(2) - 1;
                end
                else if (kind < 80)
                    raw = (raw % (last_second / SECS_PER_DAY)) * SECS_PER_DAY
                          + $urandom_range(2) - 1;
                else if (kind < 88)
                    raw = ($urandom_range(1) != 0) ? last_second + $urandom_range(6) - 3
                                                   : 64'($urandom_range(4)) - 2;
                pending_seconds.push_back(raw);
            end
        end
        repeat (END_WAIT) @(negedge clk);
        $display("Converted %0d words into %0d dates: %0d clamped to the epoch, %0d saturated.",
                 words_sent, dates_seen, clamped_count, saturated_count);
        $display("Input held off for %0d cycles while the output was stalled.",
                 input_stall_cycles);
        if (fail_count == 0 && expected_dates.size() == 0)
            $display("epoch_seconds_to_calendar test passed");
        else
            $display("epoch_seconds_to_calendar test failed");
        $finish;
    end

endmodule
